// ===== sv/alpra_pkg.sv =====
// Package for the audio latency PI rate adjuster.
// Widths, register codes, reset values and shared types; no dependencies.
package alpra_pkg;

  localparam int unsigned WINDOW_DEPTH = 128;
  localparam int unsigned SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam int unsigned LAT_W      = 20;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned ERR_W      = 21;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned ADJ_W      = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned PROD_I_W = GAIN_W + 1 + SUM_W;
  localparam int unsigned ACC_W    = PROD_I_W + 1;

  localparam int unsigned RND_SHIFT     = 10;
  localparam int unsigned ADJ_LIMIT_EXP = 29;

  localparam logic [LAT_W-1:0]  TARGET_RST = LAT_W'(20000);
  localparam logic [GAIN_W-1:0] KP_RST     = GAIN_W'(109951);
  localparam logic [GAIN_W-1:0] KI_RST     = GAIN_W'(1100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 2'd0,
    REG_KP     = 2'd1,
    REG_KI     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] sum;
  } win_result_t;

endpackage

// ===== sv/audio_latency_pi_rate_adjust.sv =====
// Throughput: one word per cycle while out_stall_i is low.
// Stages: window update, two gain multipliers, sum/round/clamp into the output register.
// The window store read is prefetched, so back-to-back words stall only on output backpressure.
// Reset: asynchronous, active low; gains and target return to defaults, the window
// reads as empty until refilled, no clearing pass.
// Depends on alpra_pkg and alpra_window.
module audio_latency_pi_rate_adjust import alpra_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [LAT_W-1:0]        measured_latency_us_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ADJ_W-1:0] rate_adjust_o,
  output logic signed [ERR_W-1:0] latency_error_o,
  output logic signed [SUM_W-1:0] error_window_sum_o
);

  localparam logic signed [ACC_W-1:0] ADJ_LIM = ACC_W'(1) <<< ADJ_LIMIT_EXP;
  localparam logic signed [ACC_W-1:0] RND_ADD = ACC_W'(1) <<< (RND_SHIFT - 1);

  logic [LAT_W-1:0]  target_q;
  logic [GAIN_W-1:0] kp_q, ki_q;

  logic        s1_v_q, s2_v_q, out_v_q;
  logic        s1_rdy, s2_rdy, out_rdy, accept;
  win_result_t win_res, s1_q, s2_q, out_q;

  logic signed [PROD_P_W-1:0] prod_p_q;
  logic signed [PROD_I_W-1:0] prod_i_q;
  logic signed [ACC_W-1:0]    acc, shifted, adj;
  logic signed [ADJ_W-1:0]    adj_q;

  assign out_rdy    = !out_v_q || !out_stall_i;
  assign s2_rdy     = !s2_v_q || out_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign accept     = in_valid_i && s1_rdy;
  assign in_stall_o = !s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      kp_q     <= KP_RST;
      ki_q     <= KI_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TARGET: target_q <= cfg_wdata_i[LAT_W-1:0];
        REG_KP:     kp_q     <= cfg_wdata_i[GAIN_W-1:0];
        REG_KI:     ki_q     <= cfg_wdata_i[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  alpra_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .target_i   (target_q),
    .measured_i (measured_latency_us_i),
    .res_o      (win_res)
  );

  assign acc     = ACC_W'(prod_p_q) + ACC_W'(prod_i_q) + RND_ADD;
  assign shifted = acc >>> RND_SHIFT;
  assign adj     = (shifted > ADJ_LIM) ? ADJ_LIM : (shifted < -ADJ_LIM) ? -ADJ_LIM : shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= win_res;
    end
    if (s2_rdy && s1_v_q) begin
      s2_q     <= s1_q;
      prod_p_q <= $signed({1'b0, kp_q}) * s1_q.err;
      prod_i_q <= $signed({1'b0, ki_q}) * s1_q.sum;
    end
    if (out_rdy && s2_v_q) begin
      out_q <= s2_q;
      adj_q <= adj[ADJ_W-1:0];
    end
  end

  assign out_valid_o        = out_v_q;
  assign rate_adjust_o      = adj_q;
  assign latency_error_o    = out_q.err;
  assign error_window_sum_o = out_q.sum;

endmodule

// ===== sv/alpra_window.sv =====
// Error history window: circular store, running sum and slot pointer.
// Depends on alpra_pkg.
module alpra_window import alpra_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [LAT_W-1:0] target_i,
  input  logic [LAT_W-1:0] measured_i,
  output win_result_t      res_o
);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  logic signed [ERR_W-1:0] mem [WINDOW_DEPTH];
  logic signed [ERR_W-1:0] rd_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SLOT_W-1:0]       slot_q, slot_nx, slot_rd;
  logic                    wrapped_q;
  logic signed [ERR_W-1:0] old_err, err;

  // entries read as zero until the pointer has gone round once
  assign old_err = wrapped_q ? rd_q : '0;
  assign err     = $signed({1'b0, target_i}) - $signed({1'b0, measured_i});
  assign sum_d   = sum_q - SUM_W'(old_err) + SUM_W'(err);
  assign slot_nx = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
  assign slot_rd = accept_i ? slot_nx : slot_q;

  assign res_o.err = err;
  assign res_o.sum = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      slot_q    <= '0;
      wrapped_q <= 1'b0;
    end else if (accept_i) begin
      sum_q  <= sum_d;
      slot_q <= slot_nx;
      if (slot_q == SLOT_LAST) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // read prefetches the slot the next word will use
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem[slot_q] <= err;
    end
    rd_q <= mem[slot_rd];
  end

endmodule

// ===== sv/alpra_checker.sv =====
// Port-level checks for the rate adjuster, bound to the top level.
// Depends on alpra_pkg and audio_latency_pi_rate_adjust.
module alpra_checker import alpra_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [ADJ_W-1:0] rate_adjust_o
);

  localparam logic signed [ADJ_W-1:0] LIM = ADJ_W'(1) <<< ADJ_LIMIT_EXP;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rate_adjust_o))
    else $error("stalled result changed");

  a_adj_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rate_adjust_o <= LIM) && (rate_adjust_o >= -LIM))
    else $error("rate adjust outside limit");

  // input backs up only behind a full, stalled pipeline
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind audio_latency_pi_rate_adjust alpra_checker u_alpra_checker (.*);
